// File: design/gradient_non_max_suppression_core_defines.svh
// ----------------------------------------------------------------------------
// gradient non-max suppression assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NON_MAX_SUPPRESSION_CORE_DEFINES_SVH
`define GRADIENT_NON_MAX_SUPPRESSION_CORE_DEFINES_SVH

// same-cycle implication
`define GNMS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gnms assertion failed");

// next-cycle implication
`define GNMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gnms assertion failed");

`endif

// File: design/gnms_pkg.sv
// ----------------------------------------------------------------------------
// gnms_pkg
// types, constants and the angle quantizer for gradient non-max suppression
// ----------------------------------------------------------------------------
package gnms_pkg;

	// sizes
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAG_BITS   = 16;
	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
	localparam int FW_BITS    = 12;
	localparam int FH_BITS    = 13;
	localparam int CFG_BITS   = 13;
	localparam int ANG_BITS   = 10;
	localparam int MIN_DIM    = 3;

	// result queue
	localparam int OUT_DEPTH    = 3;
	localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

	// angle constants in half degrees
	localparam int HALF_TURN  = 360;  // 180 degrees
	localparam int ANG_22_5   = 45;
	localparam int ANG_67_5   = 135;
	localparam int ANG_112_5  = 225;
	localparam int ANG_157_5  = 315;

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(640);
	localparam logic [FH_BITS-1:0] FH_RESET = FH_BITS'(480);

	typedef enum logic [1:0] {
		DIR_HORZ,
		DIR_DIAG45,
		DIR_VERT,
		DIR_DIAG135
	} gnms_dir_t;

	// one line buffer entry: two rows above plus direction of the row above
	typedef struct packed {
		logic [MAG_BITS-1:0] line1;
		logic [MAG_BITS-1:0] line0;
		gnms_dir_t           dir;
	} gnms_line_t;

	// item in the stage after the line buffer read
	typedef struct packed {
		logic                valid;
		logic [MAG_BITS-1:0] mag;
		gnms_dir_t           dir;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
	} gnms_s1_t;

	// result item
	typedef struct packed {
		logic [MAG_BITS-1:0] kept;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
	} gnms_result_t;

	// reduce modulo 180 degrees and pick one of four directions
	function automatic gnms_dir_t quantize_angle(input logic [ANG_BITS-1:0] ang);
		logic [ANG_BITS-1:0] a;
		gnms_dir_t           d;
		if (ang >= ANG_BITS'(2 * HALF_TURN))
			a = ang - ANG_BITS'(2 * HALF_TURN);
		else if (ang >= ANG_BITS'(HALF_TURN))
			a = ang - ANG_BITS'(HALF_TURN);
		else
			a = ang;
		if (a < ANG_BITS'(ANG_22_5) || a >= ANG_BITS'(ANG_157_5))
			d = DIR_HORZ;
		else if (a < ANG_BITS'(ANG_67_5))
			d = DIR_DIAG45;
		else if (a < ANG_BITS'(ANG_112_5))
			d = DIR_VERT;
		else
			d = DIR_DIAG135;
		return d;
	endfunction

endpackage

// File: design/gnms_line_buffer.sv
// ----------------------------------------------------------------------------
// gnms_line_buffer
// line memory holding two rows of magnitudes and one row of directions,
// registered read with write-to-read forwarding for the same column
// ----------------------------------------------------------------------------
module gnms_line_buffer
	import gnms_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [COL_BITS-1:0] rd_addr,
	input  logic                wr_en,
	input  logic [COL_BITS-1:0] wr_addr,
	input  gnms_line_t          wr_data,
	output gnms_line_t          rd_data
);

	gnms_line_t mem [MAX_WIDTH];
	gnms_line_t rd_q;
	gnms_line_t fwd_q;
	logic       fwd_sel_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
		fwd_q <= wr_data;
	end

	// read of a column written in the same cycle takes the new entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_sel_q <= 1'b0;
		else if (rd_en)
			fwd_sel_q <= wr_en && (wr_addr == rd_addr);
	end

	assign rd_data = fwd_sel_q ? fwd_q : rd_q;

endmodule

// File: design/gnms_window.sv
// ----------------------------------------------------------------------------
// gnms_window
// 3x3 magnitude window and the directional local maximum test
// ----------------------------------------------------------------------------
module gnms_window
	import gnms_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  gnms_s1_t     item_s1,
	input  gnms_line_t   col_in,
	output logic         push,
	output gnms_result_t result
);

	// window columns 1 and 2; column 0 after a shift is the old column 1
	logic [MAG_BITS-1:0] w01_q, w02_q, w11_q, w12_q, w21_q, w22_q;
	gnms_dir_t           dir_hold_q;

	logic [MAG_BITS-1:0] centre, n1, n2;
	logic                interior;

	// neighbors along the centre direction, as seen after the shift
	always_comb begin
		centre = w12_q;
		case (dir_hold_q)
			DIR_HORZ: begin
				n1 = w11_q;
				n2 = col_in.line0;
			end
			DIR_DIAG45: begin
				n1 = col_in.line1;
				n2 = w21_q;
			end
			DIR_VERT: begin
				n1 = w02_q;
				n2 = w22_q;
			end
			default: begin
				n1 = w01_q;
				n2 = item_s1.mag;
			end
		endcase
	end

	assign interior = (item_s1.row >= ROW_BITS'(2)) && (item_s1.col >= COL_BITS'(2));

	// result item, first row and first column give zero
	assign push        = item_s1.valid && (item_s1.row != '0) && (item_s1.col != '0);
	assign result.kept = (interior && centre >= n1 && centre >= n2) ? centre : '0;
	assign result.row  = item_s1.row - ROW_BITS'(1);
	assign result.col  = item_s1.col - COL_BITS'(1);

	// window shift and centre direction pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w01_q      <= '0;
			w02_q      <= '0;
			w11_q      <= '0;
			w12_q      <= '0;
			w21_q      <= '0;
			w22_q      <= '0;
			dir_hold_q <= DIR_HORZ;
		end else if (item_s1.valid) begin
			w01_q      <= w02_q;
			w02_q      <= col_in.line1;
			w11_q      <= w12_q;
			w12_q      <= col_in.line0;
			w21_q      <= w22_q;
			w22_q      <= item_s1.mag;
			dir_hold_q <= col_in.dir;
		end
	end

endmodule

// File: design/gnms_out_fifo.sv
// ----------------------------------------------------------------------------
// gnms_out_fifo
// three-entry result queue between the pipeline and the output channel
// ----------------------------------------------------------------------------
module gnms_out_fifo
	import gnms_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  gnms_result_t            push_data,
	input  logic                    pop,
	output logic                    not_empty,
	output logic [OUT_CNT_BITS-1:0] count,
	output gnms_result_t            head
);

	gnms_result_t            slot_q [OUT_DEPTH];
	logic [OUT_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUT_CNT_BITS-1:0] count_q;
	logic                    do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign not_empty = count_q != '0;
	assign count     = count_q;
	assign head      = slot_q[rd_ptr_q];

	// payload slots
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0
					: wr_ptr_q + OUT_PTR_BITS'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0
					: rd_ptr_q + OUT_PTR_BITS'(1);
			case ({push, do_pop})
				2'b10:   count_q <= count_q + OUT_CNT_BITS'(1);
				2'b01:   count_q <= count_q - OUT_CNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/gradient_non_max_suppression_core.sv
// ----------------------------------------------------------------------------
// gradient_non_max_suppression_core
// canny non-maximum suppression over a raster pixel stream
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  input    in_valid / in_ready    grad_magnitude, grad_angle, frame_start
//  output   out_valid / out_ready  kept_magnitude, pixel_row, pixel_col
//  config   cfg_we                 cfg_index, cfg_wdata
//
// one item per cycle sustained while in_ready is high.
// the line memory is read when an item is accepted and written back in the
// next cycle, so the read-modify-write of one column sets the one-item pace.
// in_ready drops when queued results plus the item in stage 1 would fill the
// three-entry result queue. reset clears counters, window and queue; the line
// memory needs no clearing pass.
// ----------------------------------------------------------------------------
module gradient_non_max_suppression_core
	import gnms_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [MAG_BITS-1:0] grad_magnitude,
	input  logic [ANG_BITS-1:0] grad_angle,
	input  logic                frame_start,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [MAG_BITS-1:0] kept_magnitude,
	output logic [ROW_BITS-1:0] pixel_row,
	output logic [COL_BITS-1:0] pixel_col,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_BITS-1:0] cfg_wdata
);

	logic [FW_BITS-1:0]      frame_width_q, eff_width;
	logic [FH_BITS-1:0]      frame_height_q, eff_height;
	logic [ROW_BITS-1:0]     row_q, pos_row;
	logic [COL_BITS-1:0]     col_q, pos_col;
	logic                    accept, col_last, row_last;
	logic [OUT_CNT_BITS-1:0] fifo_count;
	gnms_s1_t                item_s1;
	gnms_line_t              line_rd, line_wr;
	gnms_result_t            result, head;
	logic                    push;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[FW_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	// frame size clamped to the supported range
	always_comb begin
		if (frame_width_q < FW_BITS'(MIN_DIM))
			eff_width = FW_BITS'(MIN_DIM);
		else if (frame_width_q > FW_BITS'(MAX_WIDTH))
			eff_width = FW_BITS'(MAX_WIDTH);
		else
			eff_width = frame_width_q;
		if (frame_height_q < FH_BITS'(MIN_DIM))
			eff_height = FH_BITS'(MIN_DIM);
		else if (frame_height_q > FH_BITS'(MAX_HEIGHT))
			eff_height = FH_BITS'(MAX_HEIGHT);
		else
			eff_height = frame_height_q;
	end

	// input handshake, room for every item already in flight
	assign in_ready = ({1'b0, fifo_count} + (OUT_CNT_BITS + 1)'(item_s1.valid))
		< (OUT_CNT_BITS + 1)'(OUT_DEPTH);
	assign accept   = in_valid && in_ready;

	// position of the accepted item
	assign pos_row  = frame_start ? '0 : row_q;
	assign pos_col  = frame_start ? '0 : col_q;
	assign col_last = ({1'b0, pos_col} + FW_BITS'(1)) >= eff_width;
	assign row_last = ({1'b0, pos_row} + FH_BITS'(1)) >= eff_height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : pos_row + ROW_BITS'(1);
			end else begin
				col_q <= pos_col + COL_BITS'(1);
				row_q <= pos_row;
			end
		end
	end

	// stage 1: item beside its line memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1.valid <= accept;
			if (accept) begin
				item_s1.mag <= grad_magnitude;
				item_s1.dir <= quantize_angle(grad_angle);
				item_s1.row <= pos_row;
				item_s1.col <= pos_col;
			end
		end
	end

	// write back: row above moves up, this item becomes the row above
	assign line_wr.line1 = line_rd.line0;
	assign line_wr.line0 = item_s1.mag;
	assign line_wr.dir   = item_s1.dir;

	gnms_line_buffer u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (pos_col),
		.wr_en   (item_s1.valid),
		.wr_addr (item_s1.col),
		.wr_data (line_wr),
		.rd_data (line_rd)
	);

	gnms_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.col_in  (line_rd),
		.push    (push),
		.result  (result)
	);

	gnms_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.pop       (out_ready),
		.not_empty (out_valid),
		.count     (fifo_count),
		.head      (head)
	);

	assign kept_magnitude = head.kept;
	assign pixel_row      = head.row;
	assign pixel_col      = head.col;

endmodule

// File: design/gnms_checker.sv
// ----------------------------------------------------------------------------
// gnms_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "gradient_non_max_suppression_core_defines.svh"

module gnms_checker
	import gnms_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [MAG_BITS-1:0] kept_magnitude,
	input  logic [ROW_BITS-1:0] pixel_row,
	input  logic [COL_BITS-1:0] pixel_col
);

	logic [MAG_BITS+ROW_BITS+COL_BITS-1:0] out_payload;

	assign out_payload = {kept_magnitude, pixel_row, pixel_col};

	// a stalled result stays offered
	`GNMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// a stalled result keeps its payload
	`GNMS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_payload))

	// a kept magnitude never belongs to the first row or column
	`GNMS_ASSERT_IMPL(a_border_zero, out_valid && kept_magnitude != '0, pixel_row != '0 && pixel_col != '0)

	// the last column of the widest row is never emitted
	`GNMS_ASSERT_IMPL(a_last_col, out_valid, pixel_col != COL_BITS'(MAX_WIDTH - 1))

endmodule

bind gradient_non_max_suppression_core gnms_checker u_gnms_checker (.*);
